@@ sv/mbm_pkg.sv @@
// Shared types, codes and the CRC-16 step for the Modbus RTU master.
// No dependencies; the transaction engine refers to this package by scoped names.
package mbm_pkg;

	localparam int RX_BUFFER_BYTES_DEF = 32;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	// Address, function, byte count and the two CRC bytes around the payload.
	localparam int FRAME_OVERHEAD = 5;
	localparam int REQ_BYTES = 8;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_OK      = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  slave_id;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] register_count;
		logic [15:0] timeout_ticks;
		logic [7:0]  rx_byte;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic        header_match;
		logic [7:0]  byte_count;
		logic [31:0] data_word;
		logic [5:0]  frame_length;
	} rsp_t;

	// One byte of the reflected CRC-16, eight shift steps unrolled.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/mbm_stream_if.sv @@
// Valid/ready channel carrying one item of a packed payload type.
// Used with mbm_pkg::cmd_t and mbm_pkg::rsp_t by the Modbus RTU master.
interface mbm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/modbus_rtu_master_transaction.sv @@
// Modbus RTU master transaction engine: builds a read request with its CRC-16 and checks
// the response. Depends on mbm_pkg and mbm_stream_if.
//
// Command items (start, received byte, millisecond tick) enter an input register and are
// processed at a rate of one per cycle while the response channel keeps up and no request
// burst runs. A received byte or a tick yields at most one response item (ok, CRC error or
// timeout) in the cycle after processing. A start yields eight transmit items, taken from
// a small request generator that feeds the request CRC one byte per cycle unless stalled;
// while that burst runs, the next command waits in the input register, so a start holds the
// output port for all eight request bytes. A stalled response holds the output register
// and, behind it, one command in the input register. Bytes beyond RX_BUFFER_BYTES, bytes
// and ticks while idle, and unknown operations are dropped without a response.
module modbus_rtu_master_transaction #(
	parameter int RX_BUFFER_BYTES = mbm_pkg::RX_BUFFER_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mbm_stream_if.sink  cmd,
	mbm_stream_if.source rsp
);

	localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);
	localparam int IDX_W = (CNT_W > 6) ? CNT_W : 6;
	localparam int CMP_W = 9;

	// Input register.
	logic         valid_s1;
	mbm_pkg::cmd_t cmd_s1;

	// Output register and request generator.
	logic          out_valid_q;
	mbm_pkg::rsp_t out_q;
	logic          burst_active_q;
	logic [2:0]    burst_idx_q;
	logic [15:0]   tx_crc_q;
	logic [15:0]   req_addr_q;
	logic [15:0]   req_count_q;

	// Transaction state.
	logic             waiting_q;
	logic [IDX_W-1:0] rx_index_q;
	logic [7:0]       byte_count_q;
	logic [15:0]      running_crc_q;
	logic [15:0]      crc_hist_q;
	logic [7:0]       saved_slave_q;
	logic [7:0]       saved_function_q;
	logic [31:0]      payload_q;
	logic [15:0]      tick_q;
	logic [15:0]      timeout_q;
	logic             header_ok_q;

	logic out_free;
	logic proc;
	logic burst_step;
	logic is_start;

	// Next-state values of one processed command.
	logic             waiting_n;
	logic [IDX_W-1:0] rx_index_n;
	logic [7:0]       byte_count_n;
	logic [15:0]      running_crc_n;
	logic [15:0]      crc_hist_n;
	logic [31:0]      payload_n;
	logic [15:0]      tick_n;
	logic             header_ok_n;
	logic             rep_valid;
	mbm_pkg::kind_t   rep_kind;

	logic [7:0]    burst_byte;
	mbm_pkg::rsp_t rep_item;
	mbm_pkg::rsp_t tx_item;

	assign out_free   = !out_valid_q || rsp.ready;
	assign proc       = valid_s1 && out_free && !burst_active_q;
	assign burst_step = burst_active_q && out_free;
	assign is_start   = (cmd_s1.operation == mbm_pkg::OP_START);
	assign cmd.ready  = !valid_s1 || proc;
	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_q;

	always_comb begin
		logic [7:0]           b;
		logic [CMP_W-1:0]     expected;
		logic [15:0]          got;
		waiting_n     = waiting_q;
		rx_index_n    = rx_index_q;
		byte_count_n  = byte_count_q;
		running_crc_n = running_crc_q;
		crc_hist_n    = crc_hist_q;
		payload_n     = payload_q;
		tick_n        = tick_q;
		header_ok_n   = header_ok_q;
		rep_valid     = 1'b0;
		rep_kind      = mbm_pkg::KIND_TIMEOUT;
		b             = cmd_s1.rx_byte;
		expected      = '0;
		got           = '0;
		case (cmd_s1.operation)
			mbm_pkg::OP_START: begin
				waiting_n     = 1'b1;
				rx_index_n    = '0;
				byte_count_n  = '0;
				running_crc_n = mbm_pkg::CRC_SEED;
				crc_hist_n    = '0;
				payload_n     = '0;
				tick_n        = '0;
				header_ok_n   = 1'b0;
			end
			mbm_pkg::OP_BYTE: begin
				if (waiting_q && (rx_index_q < IDX_W'(RX_BUFFER_BYTES))) begin
					// The running CRC trails by two bytes so the last two are the check value.
					if (rx_index_q >= IDX_W'(2)) begin
						running_crc_n = mbm_pkg::crc_feed(running_crc_q, crc_hist_q[15:8]);
					end
					crc_hist_n = {crc_hist_q[7:0], b};
					if (rx_index_q == IDX_W'(0)) begin
						header_ok_n = (b == saved_slave_q);
					end else if (rx_index_q == IDX_W'(1)) begin
						header_ok_n = header_ok_q && (b == saved_function_q);
					end else if (rx_index_q == IDX_W'(2)) begin
						byte_count_n = b;
					end else if (rx_index_q == IDX_W'(3)) begin
						payload_n[31:24] = b;
					end else if (rx_index_q == IDX_W'(4)) begin
						payload_n[23:16] = b;
					end else if (rx_index_q == IDX_W'(5)) begin
						payload_n[15:8] = b;
					end else if (rx_index_q == IDX_W'(6)) begin
						payload_n[7:0] = b;
					end
					rx_index_n = rx_index_q + IDX_W'(1);
					expected = CMP_W'(mbm_pkg::FRAME_OVERHEAD) + {1'b0, byte_count_n};
					got = {crc_hist_n[7:0], crc_hist_n[15:8]};
					if ((rx_index_n >= IDX_W'(mbm_pkg::FRAME_OVERHEAD)) &&
					    (CMP_W'(rx_index_n) == expected)) begin
						rep_valid = 1'b1;
						rep_kind  = (got == running_crc_n) ? mbm_pkg::KIND_OK
						                                   : mbm_pkg::KIND_CRC_ERR;
						waiting_n = 1'b0;
					end
				end
			end
			mbm_pkg::OP_TICK: begin
				if (waiting_q) begin
					tick_n = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
					if (tick_n >= timeout_q) begin
						rep_valid = 1'b1;
						rep_kind  = mbm_pkg::KIND_TIMEOUT;
						waiting_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rep_item              = '0;
		rep_item.kind         = rep_kind;
		rep_item.header_match = (rx_index_n >= IDX_W'(2)) && header_ok_n;
		rep_item.byte_count   = byte_count_n;
		rep_item.data_word    = payload_n;
		rep_item.frame_length = rx_index_n[5:0];
	end

	always_comb begin
		case (burst_idx_q)
			3'd1:    burst_byte = saved_function_q;
			3'd2:    burst_byte = req_addr_q[15:8];
			3'd3:    burst_byte = req_addr_q[7:0];
			3'd4:    burst_byte = req_count_q[15:8];
			3'd5:    burst_byte = req_count_q[7:0];
			3'd6:    burst_byte = tx_crc_q[7:0];
			3'd7:    burst_byte = tx_crc_q[15:8];
			default: burst_byte = saved_slave_q;
		endcase
	end

	// The first request byte comes straight from the start item, the rest from the burst.
	always_comb begin
		tx_item         = '0;
		tx_item.kind    = mbm_pkg::KIND_TX;
		tx_item.tx_byte = burst_active_q ? burst_byte : cmd_s1.slave_id;
		tx_item.last    = burst_active_q && (burst_idx_q == 3'(mbm_pkg::REQ_BYTES - 1));
	end

	// Control and transaction state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
			burst_active_q   <= 1'b0;
			burst_idx_q      <= '0;
			tx_crc_q         <= mbm_pkg::CRC_SEED;
			waiting_q        <= 1'b0;
			rx_index_q       <= '0;
			byte_count_q     <= '0;
			running_crc_q    <= mbm_pkg::CRC_SEED;
			crc_hist_q       <= '0;
			saved_slave_q    <= '0;
			saved_function_q <= '0;
			payload_q        <= '0;
			tick_q           <= '0;
			timeout_q        <= '0;
			header_ok_q      <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end

			if (proc) begin
				waiting_q     <= waiting_n;
				rx_index_q    <= rx_index_n;
				byte_count_q  <= byte_count_n;
				running_crc_q <= running_crc_n;
				crc_hist_q    <= crc_hist_n;
				payload_q     <= payload_n;
				tick_q        <= tick_n;
				header_ok_q   <= header_ok_n;
				if (is_start) begin
					saved_slave_q    <= cmd_s1.slave_id;
					saved_function_q <= cmd_s1.function_code;
					timeout_q        <= cmd_s1.timeout_ticks;
				end
			end

			if (proc && is_start) begin
				out_valid_q    <= 1'b1;
				burst_active_q <= 1'b1;
				burst_idx_q    <= 3'd1;
				tx_crc_q       <= mbm_pkg::crc_feed(mbm_pkg::CRC_SEED, cmd_s1.slave_id);
			end else if (proc && rep_valid) begin
				out_valid_q <= 1'b1;
			end else if (burst_step) begin
				out_valid_q <= 1'b1;
				burst_idx_q <= burst_idx_q + 3'd1;
				if (burst_idx_q < 3'd6) begin
					tx_crc_q <= mbm_pkg::crc_feed(tx_crc_q, burst_byte);
				end
				if (burst_idx_q == 3'd7) begin
					burst_active_q <= 1'b0;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
		if (proc && is_start) begin
			req_addr_q  <= cmd_s1.start_address;
			req_count_q <= cmd_s1.register_count;
			out_q       <= tx_item;
		end else if (proc && rep_valid) begin
			out_q <= rep_item;
		end else if (burst_step) begin
			out_q <= tx_item;
		end
	end

endmodule
